[hdl/dtdr_pkg.sv]
// ----------------------------------------------------------------------------
// dtdr_pkg: shared types and constants for the divider timer
// Operation codes, register selects, item and result structs, divider taps.
// ----------------------------------------------------------------------------
package dtdr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_RESET = 2'd3
  } op_t;

  localparam logic [2:0] REG_DIV  = 3'd0;
  localparam logic [2:0] REG_TIMA = 3'd1;
  localparam logic [2:0] REG_TMA  = 3'd2;
  localparam logic [2:0] REG_TAC  = 3'd3;

  localparam int unsigned TAC_ENABLE_BIT = 2;
  localparam logic [15:0] DIV_NO_BOOT    = 16'h0018;
  localparam logic [7:0]  READ_UNMAPPED  = 8'hFF;

  // Countdown values: TMA reloads into TIMA, interrupt fires, cancel window top
  localparam logic [3:0] CNT_RELOAD_FIRST = 4'd4;
  localparam logic [3:0] CNT_RELOAD_IRQ   = 4'd2;
  localparam logic [3:0] CNT_CANCEL_HI    = 4'd7;

  // Divider bit feeding TIMA for each TAC rate code
  localparam int unsigned DIV_TAP_RATE0 = 9;
  localparam int unsigned DIV_TAP_RATE1 = 3;
  localparam int unsigned DIV_TAP_RATE2 = 5;
  localparam int unsigned DIV_TAP_RATE3 = 7;

  typedef struct packed {
    op_t        op;
    logic [2:0] reg_sel;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } result_t;

  typedef struct packed {
    logic       reload_pending;
    logic [3:0] reload_countdown;
  } status_t;

  function automatic logic div_tap(input logic [15:0] div, input logic [1:0] rate);
    logic bit_v;
    unique case (rate)
      2'd0:    bit_v = div[DIV_TAP_RATE0];
      2'd1:    bit_v = div[DIV_TAP_RATE1];
      2'd2:    bit_v = div[DIV_TAP_RATE2];
      default: bit_v = div[DIV_TAP_RATE3];
    endcase
    return bit_v;
  endfunction

endpackage

[hdl/dtdr_core.sv]
// ----------------------------------------------------------------------------
// dtdr_core: timer state and single-pass step logic
// Holds DIV, TIMA, TMA, TAC and the reload countdown; applies one item per
// enabled cycle and returns its result combinationally.
// ----------------------------------------------------------------------------
module dtdr_core import dtdr_pkg::*; #(
  parameter int unsigned RELOAD_DELAY = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step_en,
  input  item_t   item,
  input  logic    boot_rom_present,
  output result_t result,
  output status_t status
);

  logic [15:0] div_r,  div_nxt;
  logic [7:0]  tima_r, tima_nxt;
  logic [7:0]  tma_r,  tma_nxt;
  logic [7:0]  tac_r,  tac_nxt;
  logic        prev_and_r, prev_and_nxt;
  logic        pend_r, pend_nxt;
  logic [3:0]  cnt_r,  cnt_nxt;

  logic [15:0] div_inc;
  logic        now_and;
  logic        fall;
  logic [7:0]  tima_tick;
  logic        pend_tick;
  logic [3:0]  cnt_tick;
  logic [3:0]  cnt_dec;

  // Tick path: advance divider, detect falling edge, run the reload countdown
  always_comb begin
    div_inc   = div_r + 16'd1;
    now_and   = div_tap(div_inc, tac_r[1:0]) & tac_r[TAC_ENABLE_BIT];
    fall      = prev_and_r & ~now_and;
    tima_tick = fall ? tima_r + 8'd1 : tima_r;
    pend_tick = pend_r;
    cnt_tick  = cnt_r;
    if (fall && (tima_tick == 8'd0)) begin
      pend_tick = 1'b1;
      cnt_tick  = 4'(RELOAD_DELAY);
    end
    cnt_dec = cnt_tick - 4'd1;
  end

  always_comb begin
    div_nxt      = div_r;
    tima_nxt     = tima_r;
    tma_nxt      = tma_r;
    tac_nxt      = tac_r;
    prev_and_nxt = prev_and_r;
    pend_nxt     = pend_r;
    cnt_nxt      = cnt_r;
    result       = '0;
    unique case (item.op)
      OP_TICK: begin
        div_nxt      = div_inc;
        prev_and_nxt = now_and;
        tima_nxt     = tima_tick;
        pend_nxt     = pend_tick;
        cnt_nxt      = cnt_tick;
        if (pend_tick) begin
          cnt_nxt = cnt_dec;
          if ((cnt_dec == CNT_RELOAD_FIRST) || (cnt_dec == CNT_RELOAD_IRQ)) begin
            tima_nxt = tma_r;
          end
          if (cnt_dec == CNT_RELOAD_IRQ) begin
            result.timer_irq = 1'b1;
          end
          if (cnt_dec == 4'd0) begin
            pend_nxt = 1'b0;
          end
        end
      end
      OP_READ: begin
        unique case (item.reg_sel)
          REG_DIV:  result.read_data = div_r[15:8];
          REG_TIMA: result.read_data = tima_r;
          REG_TMA:  result.read_data = tma_r;
          REG_TAC:  result.read_data = tac_r;
          default:  result.read_data = READ_UNMAPPED;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_sel)
          REG_DIV: div_nxt = '0;
          REG_TIMA: begin
            // Early in the countdown a write cancels the reload; later on it is dropped
            if (pend_r && (cnt_r >= CNT_RELOAD_FIRST) && (cnt_r <= CNT_CANCEL_HI)) begin
              pend_nxt = 1'b0;
              cnt_nxt  = '0;
              tima_nxt = item.write_data;
            end else if (!(pend_r && (cnt_r < CNT_RELOAD_FIRST))) begin
              tima_nxt = item.write_data;
            end
          end
          REG_TMA: tma_nxt = item.write_data;
          REG_TAC: tac_nxt = item.write_data;
          default: ;
        endcase
      end
      default: begin
        div_nxt  = boot_rom_present ? 16'd0 : DIV_NO_BOOT;
        tima_nxt = '0;
        tma_nxt  = '0;
        tac_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r      <= '0;
      tima_r     <= '0;
      tma_r      <= '0;
      tac_r      <= '0;
      prev_and_r <= 1'b0;
      pend_r     <= 1'b0;
      cnt_r      <= '0;
    end else if (step_en) begin
      div_r      <= div_nxt;
      tima_r     <= tima_nxt;
      tma_r      <= tma_nxt;
      tac_r      <= tac_nxt;
      prev_and_r <= prev_and_nxt;
      pend_r     <= pend_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  assign status.reload_pending   = pend_r;
  assign status.reload_countdown = cnt_r;

endmodule

[hdl/divider_timer_with_delayed_reload.sv]
// ----------------------------------------------------------------------------
// divider_timer_with_delayed_reload: DIV/TIMA timer with delayed TMA reload
// Each beat passes through the input register, then the step logic into the
// result register. Throughput: one beat per cycle unless the consumer stalls,
// bounded otherwise by the single state update per cycle in the core.
// Reset: synchronous active-low; all timer state, valids and config clear.
// ----------------------------------------------------------------------------
module divider_timer_with_delayed_reload import dtdr_pkg::*; #(
  parameter int unsigned RELOAD_DELAY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: boot_rom_present
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] reg_sel, [10:3] write_data, [15:11] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] read_data
  output logic        out_tuser   // [0] timer_irq
);

  logic    boot_rom_r;
  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance;
  logic    step;
  result_t step_res;
  status_t core_status;

  // The result register frees up when empty or drained this cycle; the
  // input register moves forward whenever the result register can take it.
  assign advance   = ~out_valid_r | out_tready;
  assign step      = advance & in_valid_r;
  assign in_tready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_rom_r <= 1'b0;
    end else if (cfg_wr_en) begin
      boot_rom_r <= cfg_wr_data;
    end
  end

  // Input register: capture a beat whenever the slot is free or moving on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.op         <= op_t'(in_tuser);
      in_item_r.reg_sel    <= in_tdata[2:0];
      in_item_r.write_data <= in_tdata[10:3];
    end
  end

  // Timer state updates exactly once per item, in the cycle it leaves the
  // input register; the result lands in the output register at the same edge.
  dtdr_core #(
    .RELOAD_DELAY (RELOAD_DELAY)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (step),
    .item             (in_item_r),
    .boot_rom_present (boot_rom_r),
    .result           (step_res),
    .status           (core_status)
  );

  // Result register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.read_data;
  assign out_tuser  = out_res_r.timer_irq;

  // An interrupt beat is only produced at the second reload point, and the
  // state stays frozen while that beat waits.
  a_irq_at_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.timer_irq) |->
      (core_status.reload_pending && (core_status.reload_countdown == CNT_RELOAD_IRQ)))
    else $error("timer_irq beat without matching reload countdown");

  // With no reload pending the countdown rests at zero
  a_idle_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    !core_status.reload_pending |-> (core_status.reload_countdown == 4'd0))
    else $error("countdown nonzero while no reload pending");

  // An empty result register never blocks the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // A stalled result holds the core state still
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(core_status))
    else $error("core state moved during output stall");

endmodule

[dv/dtdr_checker.sv]
// ----------------------------------------------------------------------------
// dtdr_checker: result predictor and scoreboard for the divider timer
// Watches the config port and both streams. Every accepted input beat runs
// through a cycle-free model of the DIV/TIMA timer. Every result beat is
// compared against the oldest expected read_data/timer_irq pair.
// ----------------------------------------------------------------------------
module dtdr_checker import dtdr_pkg::*; #(
  parameter int unsigned RELOAD_DELAY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] reg_sel, [10:3] write_data, [15:11] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] read_data
  input  logic        out_tuser,  // [0] timer_irq
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        boot_rom_present;
  logic [15:0] div_cnt;
  logic [7:0]  tima_cnt;
  logic [7:0]  tma_val;
  logic [7:0]  tac_val;
  logic        prev_and;
  logic        reload_active;
  logic [3:0]  reload_cnt;
  result_t     timer_results_q[$];

  int unsigned tap_of_rate[4] = '{DIV_TAP_RATE0, DIV_TAP_RATE1, DIV_TAP_RATE2, DIV_TAP_RATE3};

  // Apply one operation to the timer state and return the result it produces
  function automatic result_t apply_timer_op(input item_t it);
    result_t r;
    logic    now_and;
    r = '0;
    case (it.op)
      OP_TICK: begin
        div_cnt = div_cnt + 16'd1;
        now_and = div_cnt[tap_of_rate[tac_val[1:0]]] && tac_val[TAC_ENABLE_BIT];
        if (prev_and && !now_and) begin
          tima_cnt = tima_cnt + 8'd1;
          if (tima_cnt == 8'd0) begin
            reload_active = 1'b1;
            reload_cnt    = 4'(RELOAD_DELAY);
          end
        end
        if (reload_active) begin
          reload_cnt = reload_cnt - 4'd1;
          if (reload_cnt == CNT_RELOAD_FIRST) tima_cnt = tma_val;
          if (reload_cnt == CNT_RELOAD_IRQ) begin
            tima_cnt    = tma_val;
            r.timer_irq = 1'b1;
          end
          if (reload_cnt == 4'd0) reload_active = 1'b0;
        end
        prev_and = now_and;
      end
      OP_READ: begin
        case (it.reg_sel)
          REG_DIV:  r.read_data = div_cnt[15:8];
          REG_TIMA: r.read_data = tima_cnt;
          REG_TMA:  r.read_data = tma_val;
          REG_TAC:  r.read_data = tac_val;
          default:  r.read_data = READ_UNMAPPED;
        endcase
      end
      OP_WRITE: begin
        case (it.reg_sel)
          REG_DIV: div_cnt = '0;
          REG_TIMA: begin
            if (!reload_active || reload_cnt > CNT_CANCEL_HI) begin
              tima_cnt = it.write_data;
            end else if (reload_cnt >= CNT_RELOAD_FIRST) begin
              // a write early in the countdown cancels the reload and wins
              reload_active = 1'b0;
              reload_cnt    = 4'd0;
              tima_cnt      = it.write_data;
            end
          end
          REG_TMA: tma_val = it.write_data;
          REG_TAC: tac_val = it.write_data;
          default: ;
        endcase
      end
      default: begin
        tima_cnt = '0;
        tma_val  = '0;
        tac_val  = '0;
        div_cnt  = boot_rom_present ? 16'd0 : DIV_NO_BOOT;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    if (!rst_n) begin
      boot_rom_present = 1'b0;
      div_cnt          = '0;
      tima_cnt         = '0;
      tma_val          = '0;
      tac_val          = '0;
      prev_and         = 1'b0;
      reload_active    = 1'b0;
      reload_cnt       = '0;
      timer_results_q.delete();
      mismatches       = 0;
      outstanding      = 0;
    end else begin
      if (cfg_wr_en) boot_rom_present = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        it.op         = op_t'(in_tuser);
        it.reg_sel    = in_tdata[2:0];
        it.write_data = in_tdata[10:3];
        timer_results_q.push_back(apply_timer_op(it));
      end
      if (out_tvalid && out_tready) begin
        if (timer_results_q.size() == 0) begin
          $error("result beat with nothing expected: read_data %h timer_irq %b",
                 out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = timer_results_q.pop_front();
          if (out_tdata !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, out_tdata);
            mismatches++;
          end
          if (out_tuser !== want.timer_irq) begin
            $error("timer_irq: expected %b, got %b", want.timer_irq, out_tuser);
            mismatches++;
          end
        end
      end
      outstanding = timer_results_q.size();
    end
  end

endmodule

[dv/tb_divider_timer_with_delayed_reload.sv]
// ----------------------------------------------------------------------------
// tb_divider_timer_with_delayed_reload: stream testbench for the divider timer
// Drives tick/read/write/reset beats into the block, first a directed pass
// through an overflow, the reload window and its special cases, then random
// overflow runs mixed with noise under four idling phases and both settings
// of boot_rom_present. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_divider_timer_with_delayed_reload;
  timeunit 1ns;
  timeprecision 1ps;
  import dtdr_pkg::*;

  localparam int unsigned RELOAD_DELAY = 8;
  localparam logic [2:0]  REG_UNMAPPED_TOP = 3'd7;
  localparam int          BEATS_PER_PHASE = 300;
  localparam int          LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [2:0] reg_sel, [10:3] write_data, [15:11] zero
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] read_data
  logic        out_tuser;  // [0] timer_irq

  int mismatches;
  int outstanding;

  // Idling knobs shared by the sender and the receiver process
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int beats_sent     = 0;

  divider_timer_with_delayed_reload #(
    .RELOAD_DELAY(RELOAD_DELAY)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  dtdr_checker #(
    .RELOAD_DELAY(RELOAD_DELAY)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs a handshake
  initial begin
    #2_000_000;
    $display("tb_divider_timer_with_delayed_reload: FAIL");
    $finish;
  end

  // Receiver: stall at random, or hold off for a counted stretch on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else begin
        out_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offer one beat at the falling edge and hold it until the block takes it.
  // Leave tvalid high on return so back-to-back beats need no re-raise.
  task automatic send_beat(input op_t op, input logic [2:0] sel, input logic [7:0] data);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, data, sel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
  endtask

  // Drop tvalid and wait for every outstanding result to come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Change boot_rom_present only with the pipeline empty
  task automatic write_boot_rom(input logic present);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= present;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Well-formed run: arm TIMA just below overflow, usually with a fast tap selected,
  // then tick through the overflow and reload window while sprinkling reads
  // and TIMA/TMA/DIV writes so some of them land inside the countdown.
  task automatic overflow_run();
    logic [7:0] tac;
    int         pick;
    tac = 8'($urandom);
    tac[TAC_ENABLE_BIT] = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 19);
    if (pick < 12) tac[1:0] = 2'd1;
    else if (pick < 17) tac[1:0] = 2'd2;
    else tac[1:0] = 2'($urandom);
    if ($urandom_range(0, 3) == 0) send_beat(OP_RESET, 3'($urandom), 8'($urandom));
    send_beat(OP_WRITE, REG_TAC, tac);
    send_beat(OP_WRITE, REG_TMA, 8'($urandom));
    send_beat(OP_WRITE, REG_TIMA, ($urandom_range(0, 9) < 7) ? 8'hFF : 8'hFE);
    if ($urandom_range(0, 1) == 0) send_beat(OP_WRITE, REG_DIV, 8'($urandom));
    repeat ($urandom_range(20, 45)) begin
      case ($urandom_range(0, 24))
        0, 1:    send_beat(OP_WRITE, REG_TIMA, 8'($urandom));
        2:       send_beat(OP_WRITE, REG_TMA, 8'($urandom));
        3, 4, 5: send_beat(OP_READ, 3'($urandom), 8'($urandom));
        6:       send_beat(OP_WRITE, REG_DIV, 8'($urandom));
        default: ;
      endcase
      send_beat(OP_TICK, 3'($urandom), 8'($urandom));
    end
  endtask

  // Noise: fully random operations, including unmapped selects and resets
  task automatic noise_burst();
    repeat ($urandom_range(3, 12))
      send_beat(op_t'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
  endtask

  initial begin
    int  phase_end;
    bit  paused;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_TICK;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed: one overflow with reload and irq, then a cancelled one
    write_boot_rom(1'b0);
    // timer reset without boot ROM leaves the divider at 0x18 (tap bit 3 high)
    send_beat(OP_RESET, REG_DIV, 8'h00);
    send_beat(OP_WRITE, REG_TAC, 8'h05);       // enabled, tap on divider bit 3
    send_beat(OP_WRITE, REG_TMA, 8'hFF);
    send_beat(OP_WRITE, REG_TIMA, 8'hFF);
    send_beat(OP_TICK, 3'd0, 8'h00);           // tap input goes high
    send_beat(OP_WRITE, REG_DIV, 8'hFF);       // clear divider; edge seen next tick
    send_beat(OP_TICK, 3'd7, 8'hFF);           // falling edge, TIMA wraps
    repeat (3) send_beat(OP_TICK, 3'd0, 8'h00); // down to first reload
    send_beat(OP_TICK, 3'd0, 8'h00);
    send_beat(OP_WRITE, REG_TIMA, 8'h00);      // late in countdown: ignored
    send_beat(OP_TICK, 3'd0, 8'h00);           // second reload raises irq
    repeat (2) send_beat(OP_TICK, 3'd0, 8'h00); // countdown ends, tap high again
    send_beat(OP_WRITE, REG_TIMA, 8'hFF);
    send_beat(OP_WRITE, REG_DIV, 8'h00);
    send_beat(OP_TICK, 3'd0, 8'h00);           // overflow again
    send_beat(OP_TICK, 3'd0, 8'h00);
    send_beat(OP_WRITE, REG_TIMA, 8'h5A);      // early in countdown: cancels reload
    send_beat(OP_WRITE, REG_UNMAPPED_TOP, 8'hAA);
    for (int s = 0; s < 8; s++) send_beat(OP_READ, 3'(s), 8'hFF);

    // ---- random: four idling phases, boot_rom_present alternating
    for (int ph = 0; ph < 4; ph++) begin
      write_boot_rom(ph[0] == 1'b0);
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // back up the block with a long receiver hold while beats keep coming
      if (ph == 0) hold_cycles = LONG_HOLD;
      phase_end = beats_sent + BEATS_PER_PHASE;
      paused    = 1'b0;
      while (beats_sent < phase_end) begin
        if ($urandom_range(0, 5) == 0) noise_burst();
        else overflow_run();
        // halfway through phase 1, pause the sender until everything is back
        if (ph == 1 && !paused && beats_sent >= phase_end - BEATS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_divider_timer_with_delayed_reload: PASS");
    end else begin
      $display("tb_divider_timer_with_delayed_reload: FAIL");
    end
    $finish;
  end

endmodule
